### hw/rtl/hcsg_pkg.sv
// Shared types and constants for the Hilbert curve step generator.
// No dependencies; imported by every RTL module and the checker.
package hcsg_pkg;

  localparam int MaxOrder   = 8;              // largest supported curve order
  localparam int OrderW     = 4;              // width of the order register
  localparam int CoordW     = MaxOrder;       // grid side is 2^MaxOrder
  localparam int CountW     = 2 * MaxOrder;   // move counter, two bits per level
  localparam logic [OrderW-1:0] OrderReset = OrderW'(4);

  typedef enum logic [1:0] {
    DirRight = 2'd0,
    DirUp    = 2'd1,
    DirLeft  = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

endpackage

### hw/rtl/hilbert_curve_step_generator.sv
// Pipeline: a request waits in the request register until the result register
// is free or being emptied, then moves into the result register.
// Throughput: one transaction per cycle unless out_ready_i holds the result; the
// move counter and position update are combinational, request to result register.
// Reset (rst_ni low, asynchronous): counter, position and done flag clear,
// curve order returns to 4, both pipeline stages empty. Depends on hcsg_pkg, hcsg_idx2pt.
module hilbert_curve_step_generator import hcsg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: curve order
  input  logic              cfg_we_i,
  input  logic [OrderW-1:0] cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              restart_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        direction_o,
  output logic [CoordW-1:0] pos_x_o,
  output logic [CoordW-1:0] pos_y_o,
  output logic              last_move_o,
  output logic              done_res_o
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [OrderW-1:0] order_q;
  logic [OrderW-1:0] eff_ord;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // orders above the maximum saturate
  assign eff_ord = (order_q > OrderW'(MaxOrder)) ? OrderW'(MaxOrder) : order_q;

  // ---------------------------------------------------------------------------
  // Request register
  // ---------------------------------------------------------------------------
  logic req_vld_q;
  logic restart_q;
  logic out_vld_q;
  logic adv;      // request moves into the result register this cycle

  assign adv        = req_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      restart_q <= restart_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Curve state
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic              fin_q, fin_d;

  // state as seen by the pending request (restart clears it first)
  logic [CountW-1:0] cnt_eff;
  logic [CoordW-1:0] x_eff, y_eff;
  logic              fin_eff;

  assign cnt_eff = restart_q ? '0 : cnt_q;
  assign x_eff   = restart_q ? '0 : cur_x_q;
  assign y_eff   = restart_q ? '0 : cur_y_q;
  assign fin_eff = restart_q ? 1'b0 : fin_q;

  // index of the final point: 4^order - 1, i.e. 2*order low ones
  logic [CountW:0]   one_sh;
  logic [CountW-1:0] total;
  logic [CountW-1:0] cnt_nxt;
  logic              is_done, is_last;

  assign one_sh  = (CountW+1)'(1) << {eff_ord, 1'b0};
  assign total   = CountW'(one_sh - (CountW+1)'(1));
  assign cnt_nxt = cnt_eff + CountW'(1);
  assign is_done = fin_eff || (cnt_eff >= total);
  assign is_last = (cnt_nxt == total);

  // both ends of the move come from the counter, so an order change
  // mid-curve stays consistent with the new curve
  point_t pt_a, pt_b;

  hcsg_idx2pt u_pt_from (
    .ord_i (eff_ord),
    .idx_i (cnt_eff),
    .pt_o  (pt_a)
  );

  hcsg_idx2pt u_pt_to (
    .ord_i (eff_ord),
    .idx_i (cnt_nxt),
    .pt_o  (pt_b)
  );

  dir_e move_dir;

  always_comb begin
    if (pt_b.x > pt_a.x) begin
      move_dir = DirRight;
    end else if (pt_b.y > pt_a.y) begin
      move_dir = DirUp;
    end else if (pt_b.x < pt_a.x) begin
      move_dir = DirLeft;
    end else begin
      move_dir = DirDown;
    end
  end

  // next state and result payload
  dir_e              dir_d;
  logic              last_d, done_d;

  always_comb begin
    if (is_done) begin
      // sticky done: report current point, no move
      cnt_d   = cnt_eff;
      cur_x_d = x_eff;
      cur_y_d = y_eff;
      fin_d   = 1'b1;
      dir_d   = DirRight;
      last_d  = 1'b0;
      done_d  = 1'b1;
    end else begin
      cnt_d   = cnt_nxt;
      cur_x_d = pt_b.x;
      cur_y_d = pt_b.y;
      fin_d   = is_last;
      dir_d   = move_dir;
      last_d  = is_last;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      fin_q   <= 1'b0;
    end else if (adv) begin
      cnt_q   <= cnt_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      fin_q   <= fin_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  dir_e              dir_q;
  logic [CoordW-1:0] pos_x_q, pos_y_q;
  logic              last_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir_q   <= dir_d;
      pos_x_q <= cur_x_d;
      pos_y_q <= cur_y_d;
      last_q  <= last_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign direction_o = dir_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign last_move_o = last_q;
  assign done_res_o  = done_q;

endmodule

### hw/rtl/hcsg_idx2pt.sv
// Curve index to grid point conversion, one level per base-4 digit.
// Depends on hcsg_pkg.
module hcsg_idx2pt import hcsg_pkg::*; (
  input  logic [OrderW-1:0] ord_i,
  input  logic [CountW-1:0] idx_i,
  output point_t            pt_o
);

  logic [CoordW-1:0] a, b, tmp, low_mask;
  logic              ra, rb;

  always_comb begin
    a        = '0;
    b        = '0;
    tmp      = '0;
    low_mask = '0;
    ra       = 1'b0;
    rb       = 1'b0;
    for (int i = 0; i < MaxOrder; i++) begin
      if (i < int'(ord_i)) begin
        ra       = idx_i[2*i+1];
        rb       = idx_i[2*i] ^ ra;
        low_mask = (CoordW'(1) << i) - CoordW'(1);
        if (!rb) begin
          // reflect within the sub-square, then transpose
          if (ra) begin
            a = a ^ low_mask;
            b = b ^ low_mask;
          end
          tmp = a;
          a   = b;
          b   = tmp;
        end
        a[i] = ra;
        b[i] = rb;
      end
    end
  end

  // axes swapped so the curve starts rightward
  assign pt_o.x = b;
  assign pt_o.y = a;

endmodule

### hw/rtl/hcsg_checker.sv
// Port-level checks for hilbert_curve_step_generator, attached by bind.
// Depends on hcsg_pkg and the top level.
module hcsg_checker import hcsg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        direction_o,
  input logic [CoordW-1:0] pos_x_o,
  input logic [CoordW-1:0] pos_y_o,
  input logic              last_move_o,
  input logic              done_res_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(direction_o) &&
    $stable(pos_x_o) && $stable(pos_y_o) && $stable(last_move_o) && $stable(done_res_o))
    else $error("result changed while stalled");

  // a done report carries no move
  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> direction_o == DirRight && !last_move_o)
    else $error("done report with move fields set");

  // a right or up move cannot end on the low edge of that axis
  a_move_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |->
    (direction_o != DirRight || pos_x_o != '0) && (direction_o != DirUp || pos_y_o != '0))
    else $error("move direction inconsistent with position");

  // a final move is never also a done report
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(last_move_o && done_res_o))
    else $error("last move and done both set");

endmodule

bind hilbert_curve_step_generator hcsg_checker u_hcsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .direction_o (direction_o),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .last_move_o (last_move_o),
  .done_res_o  (done_res_o)
);

### tb/hilbert_curve_step_generator_test.sv
// Self-checking testbench for the Hilbert curve step generator.
// Needs hcsg_pkg and the hilbert_curve_step_generator RTL with hcsg_idx2pt.
`timescale 1ns / 1ps

module hilbert_curve_step_generator_test;
  import hcsg_pkg::*;

  localparam int unsigned StallPct   = 18;   // idle share on each side, percent
  localparam int unsigned IdleLimit  = 3000; // watchdog: cycles with no transaction
  localparam int unsigned RandomReqs = 420;  // random requests to send
  localparam int unsigned DrainWait  = 8;    // pipeline is two stages deep

  // One expected move, field by field.
  typedef struct packed {
    dir_e              dir;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
    logic              done;
  } move_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [OrderW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              restart_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        direction_o;
  logic [CoordW-1:0] pos_x_o;
  logic [CoordW-1:0] pos_y_o;
  logic              last_move_o;
  logic              done_res_o;

  hilbert_curve_step_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .direction_o (direction_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .last_move_o (last_move_o),
    .done_res_o  (done_res_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the order register and the walker state.
  // ---------------------------------------------------------------------------
  logic [OrderW-1:0] order_reg;
  int unsigned       move_cnt;
  logic [CoordW-1:0] at_x, at_y;
  logic              curve_done;

  move_t       pending_moves[$];  // expected results, oldest first
  int unsigned err_cnt;
  int unsigned req_cnt;
  int unsigned move_chk_cnt;
  int unsigned done_chk_cnt;
  int unsigned idle_cycles;
  bit          gaps_on;           // random idling on both sides
  int unsigned hold_left;         // receiver hold-off, counted down by the receiver

  // Grid point number idx of an order-ord curve. Walks the base-4 digits from
  // the least significant end, folding the lower quadrant into place each level.
  function automatic point_t curve_point(int unsigned ord, int unsigned idx);
    int unsigned a, b, t, s, ra, rb, tmp;
    point_t      p;
    a = 0;
    b = 0;
    t = idx;
    for (s = 1; s < (32'd1 << ord); s = s << 1) begin
      ra = (t >> 1) & 1;
      rb = (t ^ ra) & 1;
      if (rb == 0) begin
        if (ra == 1) begin
          a = s - 1 - a;
          b = s - 1 - b;
        end
        tmp = a;
        a   = b;
        b   = tmp;
      end
      a = a + s * ra;
      b = b + s * rb;
      t = t >> 2;
    end
    // axes swapped so the curve leaves the origin to the right
    p.x = b[CoordW-1:0];
    p.y = a[CoordW-1:0];
    return p;
  endfunction

  // Advance the predictor by one request and return the move it yields.
  task automatic predict_move(input logic rs, output move_t m);
    int unsigned ord, total;
    point_t      pa, pb;
    ord   = (order_reg > MaxOrder) ? MaxOrder : order_reg;
    total = (32'd1 << (2 * ord)) - 1;
    if (rs) begin
      move_cnt   = 0;
      at_x       = '0;
      at_y       = '0;
      curve_done = 1'b0;
    end
    if (curve_done || move_cnt >= total) begin
      // done request: stays put, sticky until the next restart
      curve_done = 1'b1;
      m = '{dir: DirRight, x: at_x, y: at_y, last: 1'b0, done: 1'b1};
    end else begin
      pa = curve_point(ord, move_cnt);
      pb = curve_point(ord, move_cnt + 1);
      if (pb.x > pa.x)      m.dir = DirRight;
      else if (pb.y > pa.y) m.dir = DirUp;
      else if (pb.x < pa.x) m.dir = DirLeft;
      else                  m.dir = DirDown;
      move_cnt = move_cnt + 1;
      at_x     = pb.x;
      at_y     = pb.y;
      m.x      = pb.x;
      m.y      = pb.y;
      m.last   = (move_cnt == total);
      m.done   = 1'b0;
      if (m.last) curve_done = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver, checker and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a solid hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < StallPct);
    end
  end

  // Handshakes are sampled mid-cycle, where every signal is settled; a
  // transaction seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    move_t m;
    if (out_valid_o && out_ready_i) begin
      if (pending_moves.size() == 0) begin
        $error("result transaction with no request pending");
        err_cnt++;
      end else begin
        m = pending_moves.pop_front();
        if (m.done) done_chk_cnt++;
        else        move_chk_cnt++;
        if (direction_o !== m.dir) begin
          $error("direction: expected %0d, got %0d", m.dir, direction_o);
          err_cnt++;
        end
        if (pos_x_o !== m.x) begin
          $error("pos_x: expected %0d, got %0d", m.x, pos_x_o);
          err_cnt++;
        end
        if (pos_y_o !== m.y) begin
          $error("pos_y: expected %0d, got %0d", m.y, pos_y_o);
          err_cnt++;
        end
        if (last_move_o !== m.last) begin
          $error("last_move: expected %0d, got %0d", m.last, last_move_o);
          err_cnt++;
        end
        if (done_res_o !== m.done) begin
          $error("done_res: expected %0d, got %0d", m.done, done_res_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks; each is entered and left at a rising edge.
  // ---------------------------------------------------------------------------

  // One request transaction. A gap lowers valid first; otherwise valid stays
  // high from the previous transaction and only the payload changes.
  task automatic send_request(input logic rs);
    move_t m;
    if (gaps_on && $urandom_range(99) < StallPct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_move(rs, m);
    pending_moves.push_back(m);
    req_cnt++;
  endtask

  // Order register write, only once the block has drained.
  task automatic write_order(input int unsigned val);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_moves.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= OrderW'(val);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    order_reg = OrderW'(val);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: order 4, walker at the origin, no restart needed.
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // Order zero: done on the very first request, restart or not.
  task automatic test_order_zero();
    write_order(0);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // Order one: right, up, left (last), then done twice; raising the order
  // afterwards must not clear the sticky done.
  task automatic test_order_one();
    write_order(1);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    write_order(4);
    send_request(1'b0);
  endtask

  // Orders above the maximum saturate; going back to the max keeps counting.
  task automatic test_saturation();
    write_order(15);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    write_order(MaxOrder);
    send_request(1'b0);
  endtask

  // Order lowered mid-curve: counter carries on, then runs past the shorter
  // curve and reports done.
  task automatic test_order_drop();
    write_order(3);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    write_order(2);
    send_request(1'b0);
    write_order(1);
    send_request(1'b0);
  endtask

  // Back-to-back on both sides: a full order-3 curve with no idling at all.
  task automatic test_streaming();
    gaps_on = 1'b0;
    write_order(3);
    send_request(1'b1);
    repeat (64) send_request(1'b0);
    gaps_on = 1'b1;
  endtask

  // Receiver holds off while requests keep coming, so the pipe fills and
  // in_ready_o has to drop.
  task automatic test_backpressure();
    write_order(5);
    hold_left = 120;
    send_request(1'b1);
    repeat (40) send_request(1'b0);
  endtask

  // Mostly well-formed curves: a restart, then the whole curve plus a few
  // done requests for small orders, or a partial walk for big ones. Some runs
  // skip the restart to carry the counter over into a new order, and a few
  // stray restarts land mid-curve. The last run is cut to the request budget.
  task automatic test_random_curves();
    int unsigned start_cnt, ord, len, pick, left;
    start_cnt = req_cnt;
    while (req_cnt - start_cnt < RandomReqs) begin
      pick = $urandom_range(99);
      if (pick < 75)      ord = $urandom_range(0, 3);
      else if (pick < 80) ord = 4;
      else                ord = $urandom_range(5, 15);
      write_order(ord);
      if (ord <= 4) len = (32'd1 << (2 * ord)) - 1 + $urandom_range(0, 3);
      else          len = $urandom_range(4, 40);
      left = RandomReqs - (req_cnt - start_cnt);
      if (len + 1 > left) len = left - 1;
      send_request($urandom_range(99) >= 25);
      repeat (len) send_request($urandom_range(99) < 3);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    out_ready_i = 1'b0;
    gaps_on     = 1'b1;
    hold_left   = 0;
    err_cnt     = 0;
    req_cnt     = 0;
    move_chk_cnt = 0;
    done_chk_cnt = 0;
    idle_cycles = 0;
    order_reg   = OrderReset;
    move_cnt    = 0;
    at_x        = '0;
    at_y        = '0;
    curve_done  = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_order_zero();
    test_order_one();
    test_saturation();
    test_order_drop();
    test_streaming();
    test_backpressure();
    test_random_curves();

    // drain: every request must come back, then let the pipe settle
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_moves.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d requests over orders 0-15 (saturation, mid-curve order changes,",
             req_cnt);
    $display("restarts, back-pressure): %0d moves and %0d done reports checked",
             move_chk_cnt, done_chk_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/hcsg_pkg.sv
hw/rtl/hcsg_idx2pt.sv
hw/rtl/hilbert_curve_step_generator.sv
hw/rtl/hcsg_checker.sv
tb/hilbert_curve_step_generator_test.sv
